>>> hdl/klx_pkg.sv
// ----------------------------------------------------------------------------
// klx_pkg: shared types and constants of the keyword token lexer
// Result layout, lexer phases, token kinds, error codes and keyword match.
// ----------------------------------------------------------------------------
package klx_pkg;

  localparam int LINE_WIDTH    = 24;
  localparam int KEYWORD_CHARS = 8;
  localparam int OUT_LINE_W    = 24;
  localparam int WLEN_W        = $clog2(KEYWORD_CHARS + 2);

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_COMMENT    = 4'd1,
    PH_BUILTIN    = 4'd2,
    PH_CHAR_OPEN  = 4'd3,
    PH_CHAR_CLOSE = 4'd4,
    PH_MINUS      = 4'd5,
    PH_LESS       = 4'd6,
    PH_WORD       = 4'd7,
    PH_NUMBER     = 4'd8,
    PH_HALTED     = 4'd9
  } phase_t;

  localparam logic [4:0] K_BUILTIN = 5'd0;
  localparam logic [4:0] K_STRING  = 5'd1;
  localparam logic [4:0] K_CHAR    = 5'd2;
  localparam logic [4:0] K_LPAR    = 5'd3;
  localparam logic [4:0] K_RPAR    = 5'd4;
  localparam logic [4:0] K_PLUS    = 5'd5;
  localparam logic [4:0] K_COMMA   = 5'd6;
  localparam logic [4:0] K_ARROW   = 5'd7;
  localparam logic [4:0] K_MINUS   = 5'd8;
  localparam logic [4:0] K_COLON   = 5'd9;
  localparam logic [4:0] K_SEMI    = 5'd10;
  localparam logic [4:0] K_RECV    = 5'd11;
  localparam logic [4:0] K_NEQ     = 5'd12;
  localparam logic [4:0] K_LESS    = 5'd13;
  localparam logic [4:0] K_EQUAL   = 5'd14;
  localparam logic [4:0] K_ALT     = 5'd15;
  localparam logic [4:0] K_BLOCK   = 5'd16;
  localparam logic [4:0] K_ELSEALT = 5'd17;
  localparam logic [4:0] K_ENDALT  = 5'd18;
  localparam logic [4:0] K_ENDBLK  = 5'd19;
  localparam logic [4:0] K_ENDPAR  = 5'd20;
  localparam logic [4:0] K_ENDWHL  = 5'd21;
  localparam logic [4:0] K_PAR     = 5'd22;
  localparam logic [4:0] K_WHILE   = 5'd23;
  localparam logic [4:0] K_BOOL    = 5'd24;
  localparam logic [4:0] K_NOT     = 5'd25;
  localparam logic [4:0] K_IDENT   = 5'd26;
  localparam logic [4:0] K_INT     = 5'd27;

  localparam logic [1:0] E_NONE   = 2'd0;
  localparam logic [1:0] E_SYNTAX = 2'd1;
  localparam logic [1:0] E_CHAR   = 2'd2;
  localparam logic [1:0] E_EOF    = 2'd3;

  typedef struct packed {
    logic [4:0]            kind;
    logic                  is_value_char;
    logic [7:0]            value_char;
    logic [OUT_LINE_W-1:0] line;
    logic [1:0]            error_code;
    logic                  last;
  } res_t;

  // Up to two results per accepted transaction travel to the output queue.
  typedef struct packed {
    logic [1:0] n;
    res_t       r1;
    res_t       r0;
  } push_t;

  // The word buffer holds the first character in its low byte, so the
  // keyword patterns are the reversed spellings.
  function automatic logic [4:0] kw_kind(input logic [63:0] buf_w,
                                         input logic [WLEN_W-1:0] len);
    logic [4:0] k;
    k = K_IDENT;
    if (len == WLEN_W'(3) && buf_w == 64'("tla"))           k = K_ALT;
    else if (len == WLEN_W'(5) && buf_w == 64'("kcolb"))    k = K_BLOCK;
    else if (len == WLEN_W'(7) && buf_w == 64'("tlaesle"))  k = K_ELSEALT;
    else if (len == WLEN_W'(6) && buf_w == 64'("tladne"))   k = K_ENDALT;
    else if (len == WLEN_W'(8) && buf_w == 64'("kcolbdne")) k = K_ENDBLK;
    else if (len == WLEN_W'(6) && buf_w == 64'("rapdne"))   k = K_ENDPAR;
    else if (len == WLEN_W'(8) && buf_w == 64'("elihwdne")) k = K_ENDWHL;
    else if (len == WLEN_W'(3) && buf_w == 64'("rap"))      k = K_PAR;
    else if (len == WLEN_W'(5) && buf_w == 64'("elihw"))    k = K_WHILE;
    else if (len == WLEN_W'(4) && buf_w == 64'("eurt"))     k = K_BOOL;
    else if (len == WLEN_W'(5) && buf_w == 64'("eslaf"))    k = K_BOOL;
    else if (len == WLEN_W'(3) && buf_w == 64'("ton"))      k = K_NOT;
    return k;
  endfunction

  function automatic res_t mk_res(input logic [4:0] kind, input logic isv,
                                  input logic [7:0] ch, input logic [1:0] err,
                                  input logic [LINE_WIDTH-1:0] ln);
    res_t r;
    r.kind          = kind;
    r.is_value_char = isv;
    r.value_char    = ch;
    r.line          = OUT_LINE_W'(ln);
    r.error_code    = err;
    r.last          = 1'b0;
    return r;
  endfunction

endpackage

>>> hdl/klx_core.sv
// ----------------------------------------------------------------------------
// klx_core: lexer state and per-character step logic
// Updates the lexer state on each accepted character until it halts, and forms its results.
// ----------------------------------------------------------------------------
module klx_core import klx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] char_code,
  input  logic       end_of_file,
  output push_t      push
);

  phase_t                  ph_r, ph_nxt;
  logic [LINE_WIDTH-1:0]   lc_r, lc_nxt;
  logic [LINE_WIDTH-1:0]   tl_r, tl_nxt;
  logic [63:0]             wb_r, wb_nxt;
  logic [WLEN_W-1:0]       wl_r, wl_nxt;

  res_t       rs [2];
  logic [1:0] cnt;
  logic       st;
  logic       is_alpha, is_digit;

  assign is_alpha = (char_code >= "a" && char_code <= "z") ||
                    (char_code >= "A" && char_code <= "Z");
  assign is_digit = (char_code >= "0" && char_code <= "9");

  always_comb begin
    ph_nxt = ph_r;
    lc_nxt = lc_r;
    tl_nxt = tl_r;
    wb_nxt = wb_r;
    wl_nxt = wl_r;
    rs[0]  = '0;
    rs[1]  = '0;
    cnt    = 2'd0;
    st     = 1'b0;
    if (acc && ph_r != PH_HALTED) begin
      if (end_of_file) begin
        unique case (ph_r)
          PH_BUILTIN: begin
            rs[cnt[0]] = mk_res(K_STRING, 1'b0, 8'd0, E_NONE, tl_nxt);
            cnt = cnt + 2'd1;
          end
          PH_CHAR_OPEN: begin
            rs[cnt[0]] = mk_res(K_CHAR, 1'b0, 8'd0, E_EOF, tl_nxt);
            cnt = cnt + 2'd1;
            ph_nxt = PH_HALTED;
          end
          PH_CHAR_CLOSE: begin
            rs[cnt[0]] = mk_res(K_CHAR, 1'b0, 8'd0, E_CHAR, tl_nxt);
            cnt = cnt + 2'd1;
            ph_nxt = PH_HALTED;
          end
          PH_MINUS: begin
            rs[cnt[0]] = mk_res(K_MINUS, 1'b0, 8'd0, E_NONE, tl_nxt);
            cnt = cnt + 2'd1;
          end
          PH_LESS: begin
            rs[cnt[0]] = mk_res(K_LESS, 1'b0, 8'd0, E_NONE, tl_nxt);
            cnt = cnt + 2'd1;
          end
          PH_WORD: begin
            rs[cnt[0]] = mk_res(kw_kind(wb_r, wl_r), 1'b0, 8'd0, E_NONE, tl_nxt);
            cnt = cnt + 2'd1;
          end
          PH_NUMBER: begin
            rs[cnt[0]] = mk_res(K_INT, 1'b0, 8'd0, E_NONE, tl_nxt);
            cnt = cnt + 2'd1;
          end
          default: ;
        endcase
        // After the flush the block starts over for a new stream, unless it halted.
        if (ph_nxt != PH_HALTED) begin
          ph_nxt = PH_IDLE;
          lc_nxt = LINE_WIDTH'(1);
          tl_nxt = LINE_WIDTH'(1);
          wb_nxt = '0;
          wl_nxt = '0;
        end
      end else begin
        unique case (ph_r)
          PH_COMMENT: st = (char_code == 8'h0A);
          PH_BUILTIN: begin
            if (char_code == 8'h0A) begin
              rs[cnt[0]] = mk_res(K_STRING, 1'b0, 8'd0, E_NONE, tl_nxt);
              cnt = cnt + 2'd1;
              if (lc_nxt != '1) lc_nxt = lc_nxt + LINE_WIDTH'(1);
              ph_nxt = PH_IDLE;
            end else begin
              rs[cnt[0]] = mk_res(K_STRING, 1'b1, char_code, E_NONE, tl_nxt);
              cnt = cnt + 2'd1;
            end
          end
          PH_CHAR_OPEN: begin
            wb_nxt = {56'd0, char_code};
            ph_nxt = PH_CHAR_CLOSE;
          end
          PH_CHAR_CLOSE: begin
            if (char_code == "'") begin
              rs[0] = mk_res(K_CHAR, 1'b1, wb_r[7:0], E_NONE, tl_nxt);
              rs[1] = mk_res(K_CHAR, 1'b0, 8'd0, E_NONE, tl_nxt);
              cnt = 2'd2;
              ph_nxt = PH_IDLE;
            end else begin
              rs[cnt[0]] = mk_res(K_CHAR, 1'b0, 8'd0, E_CHAR, tl_nxt);
              cnt = cnt + 2'd1;
              ph_nxt = PH_HALTED;
            end
          end
          PH_MINUS: begin
            if (char_code == ">") begin
              rs[cnt[0]] = mk_res(K_ARROW, 1'b0, 8'd0, E_NONE, tl_nxt);
              ph_nxt = PH_IDLE;
            end else begin
              rs[cnt[0]] = mk_res(K_MINUS, 1'b0, 8'd0, E_NONE, tl_nxt);
              st = 1'b1;
            end
            cnt = cnt + 2'd1;
          end
          PH_LESS: begin
            if (char_code == "-") begin
              rs[cnt[0]] = mk_res(K_RECV, 1'b0, 8'd0, E_NONE, tl_nxt);
              ph_nxt = PH_IDLE;
            end else if (char_code == ">") begin
              rs[cnt[0]] = mk_res(K_NEQ, 1'b0, 8'd0, E_NONE, tl_nxt);
              ph_nxt = PH_IDLE;
            end else begin
              rs[cnt[0]] = mk_res(K_LESS, 1'b0, 8'd0, E_NONE, tl_nxt);
              st = 1'b1;
            end
            cnt = cnt + 2'd1;
          end
          PH_WORD: begin
            if (is_alpha || is_digit) begin
              if (wl_r < WLEN_W'(KEYWORD_CHARS))
                wb_nxt = wb_r | (64'(char_code) << {wl_r[2:0], 3'b000});
              if (wl_r < WLEN_W'(KEYWORD_CHARS + 1)) wl_nxt = wl_r + WLEN_W'(1);
              rs[cnt[0]] = mk_res(K_IDENT, 1'b1, char_code, E_NONE, tl_nxt);
            end else begin
              rs[cnt[0]] = mk_res(kw_kind(wb_r, wl_r), 1'b0, 8'd0, E_NONE, tl_nxt);
              st = 1'b1;
            end
            cnt = cnt + 2'd1;
          end
          PH_NUMBER: begin
            if (is_digit) begin
              rs[cnt[0]] = mk_res(K_INT, 1'b1, char_code, E_NONE, tl_nxt);
            end else begin
              rs[cnt[0]] = mk_res(K_INT, 1'b0, 8'd0, E_NONE, tl_nxt);
              st = 1'b1;
            end
            cnt = cnt + 2'd1;
          end
          default: st = 1'b1;
        endcase

        // Start of a new token from the current character.
        if (st) begin
          tl_nxt = lc_nxt;
          ph_nxt = PH_IDLE;
          priority if (char_code == " " || char_code == 8'h09 || char_code == 8'h0B ||
                       char_code == 8'h0C || char_code == 8'h0D) begin
          end else if (char_code == 8'h0A) begin
            if (lc_nxt != '1) lc_nxt = lc_nxt + LINE_WIDTH'(1);
          end else if (char_code == "#") begin
            ph_nxt = PH_COMMENT;
          end else if (char_code == "$") begin
            rs[cnt[0]] = mk_res(K_BUILTIN, 1'b0, 8'd0, E_NONE, tl_nxt);
            cnt = cnt + 2'd1;
            ph_nxt = PH_BUILTIN;
          end else if (char_code == "'") begin
            ph_nxt = PH_CHAR_OPEN;
          end else if (char_code == "-") begin
            ph_nxt = PH_MINUS;
          end else if (char_code == "<") begin
            ph_nxt = PH_LESS;
          end else if (char_code == "(" || char_code == ")" || char_code == "+" ||
                       char_code == "," || char_code == ":" || char_code == ";" ||
                       char_code == "=") begin
            unique case (char_code)
              "(":     rs[cnt[0]] = mk_res(K_LPAR, 1'b0, 8'd0, E_NONE, tl_nxt);
              ")":     rs[cnt[0]] = mk_res(K_RPAR, 1'b0, 8'd0, E_NONE, tl_nxt);
              "+":     rs[cnt[0]] = mk_res(K_PLUS, 1'b0, 8'd0, E_NONE, tl_nxt);
              ",":     rs[cnt[0]] = mk_res(K_COMMA, 1'b0, 8'd0, E_NONE, tl_nxt);
              ":":     rs[cnt[0]] = mk_res(K_COLON, 1'b0, 8'd0, E_NONE, tl_nxt);
              ";":     rs[cnt[0]] = mk_res(K_SEMI, 1'b0, 8'd0, E_NONE, tl_nxt);
              default: rs[cnt[0]] = mk_res(K_EQUAL, 1'b0, 8'd0, E_NONE, tl_nxt);
            endcase
            cnt = cnt + 2'd1;
          end else if (is_alpha) begin
            wb_nxt = {56'd0, char_code};
            wl_nxt = WLEN_W'(1);
            rs[cnt[0]] = mk_res(K_IDENT, 1'b1, char_code, E_NONE, tl_nxt);
            cnt = cnt + 2'd1;
            ph_nxt = PH_WORD;
          end else if (is_digit) begin
            rs[cnt[0]] = mk_res(K_INT, 1'b1, char_code, E_NONE, tl_nxt);
            cnt = cnt + 2'd1;
            ph_nxt = PH_NUMBER;
          end else begin
            rs[cnt[0]] = mk_res(K_BUILTIN, 1'b0, 8'd0, E_SYNTAX, tl_nxt);
            cnt = cnt + 2'd1;
            ph_nxt = PH_HALTED;
          end
        end
      end
    end
    if (cnt != 2'd0) rs[cnt[1]].last = 1'b1;
  end

  assign push.n  = cnt;
  assign push.r0 = rs[0];
  assign push.r1 = rs[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
      lc_r <= LINE_WIDTH'(1);
      tl_r <= LINE_WIDTH'(1);
      wb_r <= '0;
      wl_r <= '0;
    end else begin
      ph_r <= ph_nxt;
      lc_r <= lc_nxt;
      tl_r <= tl_nxt;
      wb_r <= wb_nxt;
      wl_r <= wl_nxt;
    end
  end

  a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_HALTED) |-> (push.n == 2'd0)) else $error("results while halted");
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (lc_r != '0) && (tl_r <= lc_r)) else $error("line counter out of range");
  a_wlen_cap: assert property (@(posedge clk) disable iff (!rst_n)
    wl_r <= WLEN_W'(KEYWORD_CHARS + 1)) else $error("word length overrun");

endmodule

>>> hdl/klx_out_fifo.sv
// ----------------------------------------------------------------------------
// klx_out_fifo: four-entry result queue
// Takes up to two results per cycle while not full and delivers one per transaction.
// ----------------------------------------------------------------------------
module klx_out_fifo import klx_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  full,
  output logic  out_valid,
  input  logic  out_stall,
  output res_t  out_res
);

  res_t       mem [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign full      = (cnt_r > 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign out_res   = mem[rp_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wp_nxt  = wp_r + push.n;
    rp_nxt  = rp_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push.n} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wp_r] <= push.r0;
    if (push.n == 2'd2) mem[wp_r + 2'd1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("result queue overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> (push.n == 2'd0)) else $error("push into full queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[1:0] == wp_r - rp_r)) else $error("queue pointers disagree with count");

endmodule

>>> hdl/keyword_token_lexer.sv
// ----------------------------------------------------------------------------
// keyword_token_lexer: streaming lexer with keyword recognition
// Character-in, token-result-out lexer with a small output queue.
// ----------------------------------------------------------------------------
// One character is taken per clock while the four-entry result queue has room
// for two results; each character is handled in the cycle it is accepted and
// its results sit in the queue from the next cycle on. Results leave at one per
// cycle unless stalled, so characters that cause two results (a word or operator
// closed by a token character, a complete char literal) hold the input back
// once the queue fills. After an error the block sends nothing until reset.
module keyword_token_lexer import klx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_kind,
  output logic        out_is_value_char,
  output logic [7:0]  out_value_char,
  output logic [23:0] out_line,
  output logic [1:0]  out_error_code,
  output logic        out_last
);

  push_t push;
  res_t  res;
  logic  full;

  assign in_stall = full;

  klx_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (in_valid && !full),
    .char_code   (in_char_code),
    .end_of_file (in_end_of_file),
    .push        (push)
  );

  klx_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_kind          = res.kind;
  assign out_is_value_char = res.is_value_char;
  assign out_value_char    = res.value_char;
  assign out_line          = res.line;
  assign out_error_code    = res.error_code;
  assign out_last          = res.last;

endmodule
